FILE: src/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/glpd_pkg.sv
// Package for the GIF LZW pixel decoder: sizes, action and register codes.
// No dependencies.
package glpd_pkg;
  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_DEPTH   = 4096;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int ACC_W         = 24;
  localparam int LIMIT_W       = 25;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_PULL  = 2'd1,
    ACT_START = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic CFG_MIN_CODE_SIZE = 1'b0;
  localparam logic CFG_PIXEL_LIMIT   = 1'b1;
endpackage

FILE: src/glpd_ifs.sv
// Channel interfaces of the GIF LZW pixel decoder: input, result, configuration.
// Depends on nothing but plain logic types.
interface glpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface glpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       pixel_valid;
  logic       last_pixel;
  logic       byte_taken;
  logic       pixels_pending;
  logic       frame_done;
  logic       format_error;
  modport source (output valid, pixel, pixel_valid, last_pixel, byte_taken,
                  pixels_pending, frame_done, format_error, input ready);
  modport sink   (input valid, pixel, pixel_valid, last_pixel, byte_taken,
                  pixels_pending, frame_done, format_error, output ready);
endinterface

interface glpd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [24:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: src/gif_lzw_pixel_decoder.sv
// GIF LZW pixel decoder: sub-block unframing, code unpacking, LZW decoding.
// Uses glpd_pkg and the channel interfaces in glpd_ifs.sv.
//
// Usage: in_bus transfers one item: action 0 with a stream byte (length or
// data), action 1 to pull one pixel, action 2 to start a frame from the
// configuration registers. Every item gives exactly one transfer on out_bus
// with pixel, status and byte_taken. cfg_bus writes min_code_size (index 0)
// and pixel_limit (index 1); it is always ready. min_code_size applies at the
// next frame start, pixel_limit at once. Write it only while the block is idle.
// Timing: a sequencer works one item at a time; in_bus.ready is low from the
// transfer until the result has left. A start, refused byte or length byte
// goes straight to the state that loads the output register; a pull first
// passes through a stack read state. A data byte, or a pull that empties
// the stack, runs the code decoder: it takes one code at a time from the
// accumulator, walks the prefix chain with a read and a data state per table
// entry (registered read), stacks the root character and adds the table
// entry in a finishing state.
// Reset: synchronous active-low; registers go to min_code_size 8 and
// pixel_limit 0 and a frame is started from them. No memory clearing pass.
// Stall: a result waits in the output register while out_bus.ready is low,
// and no new item is taken until it has left.
module gif_lzw_pixel_decoder (
  input  logic                   clk,
  input  logic                   rst_n,
  glpd_in_if.sink                in_bus,
  glpd_out_if.source             out_bus,
  glpd_cfg_if.sink               cfg_bus
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DEC     = 7'b0000010,
    S_WALK_RD = 7'b0000100,
    S_WALK_DT = 7'b0001000,
    S_FIN     = 7'b0010000,
    S_POP     = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    PH_FIRST = 4'b0001,
    PH_RUN   = 4'b0010,
    PH_DONE  = 4'b0100,
    PH_ERR   = 4'b1000
  } phase_t;

  localparam int AW = glpd_pkg::ADDR_W;
  localparam int CW = glpd_pkg::CNT_W;
  localparam int LW = glpd_pkg::LIMIT_W;

  // Memories
  logic [AW-1:0] prefix_mem [glpd_pkg::TABLE_DEPTH];
  logic [7:0]    suffix_mem [glpd_pkg::TABLE_DEPTH];
  logic [7:0]    stack_mem  [glpd_pkg::TABLE_DEPTH];
  logic [AW-1:0] prefix_q;
  logic [7:0]    suffix_q;
  logic [7:0]    stack_q;

  logic          st_we, tb_we;
  logic [AW-1:0] st_wa, st_ra, tb_wa;
  logic [7:0]    st_wd, tb_wd_suffix;
  logic [AW-1:0] tb_wd_prefix;

  // Registers
  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [3:0]              min_r;
  logic [LW-1:0]           limit_r;
  logic [CW-1:0]           sp_r, sp_nxt;
  logic [glpd_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [4:0]              bits_r, bits_nxt;
  logic [3:0]              width_r, width_nxt;
  logic [3:0]              start_w_r, start_w_nxt;
  logic [CW-1:0]           next_r, next_nxt;
  logic [AW-1:0]           prev_r, prev_nxt;
  logic [7:0]              bbl_r, bbl_nxt;
  logic [LW-1:0]           pix_r, pix_nxt;
  logic                    ended_r, ended_nxt;
  logic [8:0]              root_r, root_nxt;
  logic [AW-1:0]           walk_r, walk_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           code_r, code_nxt;
  logic                    rep_r, rep_nxt;
  logic                    pop_chk_r, pop_chk_nxt;
  logic [7:0]              res_pixel_r, res_pixel_nxt;
  logic                    res_valid_r, res_valid_nxt;
  logic                    res_last_r, res_last_nxt;
  logic                    res_taken_r, res_taken_nxt;
  logic                    ov_r, ov_nxt;
  logic [7:0]              o_pixel_r, o_pixel_nxt;
  logic                    o_pv_r, o_pv_nxt, o_last_r, o_last_nxt, o_taken_r, o_taken_nxt;
  logic                    o_pend_r, o_pend_nxt, o_done_r, o_done_nxt, o_err_r, o_err_nxt;

  logic                    in_acc;
  logic                    active;
  logic [AW-1:0]           clear_code, end_code;
  logic [CW-1:0]           first_entry;
  logic [glpd_pkg::ACC_W-1:0] code_mask;
  logic [AW-1:0]           code;
  logic [3:0]              m_clamp;
  logic [LW:0]             pix_sum;
  logic [CW-1:0]           next_inc;

  assign in_acc       = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE) && !ov_r;
  assign cfg_bus.ready = 1'b1;
  assign active      = (phase_r == PH_FIRST) || (phase_r == PH_RUN);
  assign clear_code  = AW'(root_r);
  assign end_code    = AW'(root_r) + AW'(1);
  assign first_entry = CW'(root_r) + CW'(2);
  assign code_mask   = (glpd_pkg::ACC_W'(1) << width_r) - glpd_pkg::ACC_W'(1);
  assign code        = AW'(acc_r & code_mask);
  assign st_ra       = AW'(sp_r - CW'(1));
  assign pix_sum     = (LW+1)'(pix_r) + (LW+1)'(cnt_r);
  assign next_inc    = next_r + CW'(1);
  assign m_clamp     = (min_r < 4'd2) ? 4'd2 : ((min_r > 4'd8) ? 4'd8 : min_r);

  // Drive the result channel
  assign out_bus.valid          = ov_r;
  assign out_bus.pixel          = o_pixel_r;
  assign out_bus.pixel_valid    = o_pv_r;
  assign out_bus.last_pixel     = o_last_r;
  assign out_bus.byte_taken     = o_taken_r;
  assign out_bus.pixels_pending = o_pend_r;
  assign out_bus.frame_done     = o_done_r;
  assign out_bus.format_error   = o_err_r;

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tb_we) begin
      prefix_mem[tb_wa] <= tb_wd_prefix;
      suffix_mem[tb_wa] <= tb_wd_suffix;
    end
    prefix_q <= prefix_mem[walk_r];
    suffix_q <= suffix_mem[walk_r];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stack_mem[st_wa] <= st_wd;
    end
    stack_q <= stack_mem[st_ra];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;     phase_nxt = phase_r;     sp_nxt = sp_r;
    acc_nxt = acc_r;         bits_nxt = bits_r;       width_nxt = width_r;
    start_w_nxt = start_w_r; next_nxt = next_r;       prev_nxt = prev_r;
    bbl_nxt = bbl_r;         pix_nxt = pix_r;         ended_nxt = ended_r;
    root_nxt = root_r;       walk_nxt = walk_r;       cnt_nxt = cnt_r;
    code_nxt = code_r;       rep_nxt = rep_r;         pop_chk_nxt = pop_chk_r;
    res_pixel_nxt = res_pixel_r; res_valid_nxt = res_valid_r;
    res_last_nxt = res_last_r;   res_taken_nxt = res_taken_r;
    ov_nxt = ov_r;           o_pixel_nxt = o_pixel_r; o_pv_nxt = o_pv_r;
    o_last_nxt = o_last_r;   o_taken_nxt = o_taken_r; o_pend_nxt = o_pend_r;
    o_done_nxt = o_done_r;   o_err_nxt = o_err_r;
    st_we = 1'b0;  st_wa = AW'(sp_r);  st_wd = 8'd0;
    tb_we = 1'b0;  tb_wa = AW'(next_r); tb_wd_prefix = prev_r; tb_wd_suffix = walk_r[7:0];

    // Drop the result once transferred
    if (ov_r && out_bus.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_pixel_nxt = 8'd0;
          res_valid_nxt = 1'b0;
          res_last_nxt  = 1'b0;
          res_taken_nxt = 1'b0;
          pop_chk_nxt   = 1'b0;
          state_nxt     = S_RESP;
          case (glpd_pkg::action_t'(in_bus.action))
            glpd_pkg::ACT_BYTE: begin
              if (sp_r == '0) begin
                res_taken_nxt = 1'b1;
                if (active && !ended_r) begin
                  if (bbl_r == 8'd0) begin
                    if (in_bus.data_byte == 8'd0) begin
                      ended_nxt = 1'b1;
                      state_nxt = S_DEC;
                    end else begin
                      bbl_nxt = in_bus.data_byte;
                    end
                  end else begin
                    acc_nxt   = acc_r | (glpd_pkg::ACC_W'(in_bus.data_byte) << bits_r);
                    bits_nxt  = bits_r + 5'd8;
                    bbl_nxt   = bbl_r - 8'd1;
                    state_nxt = S_DEC;
                  end
                end
              end
            end
            glpd_pkg::ACT_PULL: begin
              if (sp_r != '0) begin
                sp_nxt    = sp_r - CW'(1);
                state_nxt = S_POP;
              end
            end
            glpd_pkg::ACT_START: begin
              root_nxt    = 9'(1) << m_clamp;
              start_w_nxt = m_clamp + 4'd1;
              width_nxt   = m_clamp + 4'd1;
              next_nxt    = (CW'(1) << m_clamp) + CW'(2);
              acc_nxt     = '0;
              bits_nxt    = '0;
              bbl_nxt     = '0;
              ended_nxt   = 1'b0;
              pix_nxt     = '0;
              sp_nxt      = '0;
              prev_nxt    = '0;
              phase_nxt   = PH_FIRST;
            end
            default: ;
          endcase
        end
      end

      // Hand out the popped pixel; an emptied stack resumes decoding
      S_POP: begin
        res_pixel_nxt = stack_q;
        res_valid_nxt = 1'b1;
        if (sp_r == '0) begin
          res_last_nxt = (pix_r == limit_r);
          pop_chk_nxt  = 1'b1;
          state_nxt    = S_DEC;
        end else begin
          state_nxt = S_RESP;
        end
      end

      // Take one code from the accumulator and act on it
      S_DEC: begin
        if (!active || sp_r != '0) begin
          state_nxt = S_RESP;
        end else if (bits_r < {1'b0, width_r}) begin
          if (ended_r) phase_nxt = PH_DONE;
          state_nxt = S_RESP;
        end else begin
          acc_nxt  = acc_r >> width_r;
          bits_nxt = bits_r - {1'b0, width_r};
          if (phase_r == PH_FIRST) begin
            if (code < clear_code) begin
              if ((LW+1)'(pix_r) + (LW+1)'(1) > (LW+1)'(limit_r)) begin
                phase_nxt = PH_ERR;
              end else begin
                st_we     = 1'b1;
                st_wa     = '0;
                st_wd     = code[7:0];
                sp_nxt    = CW'(1);
                pix_nxt   = pix_r + LW'(1);
                prev_nxt  = code;
                phase_nxt = PH_RUN;
              end
            end else if (code != clear_code) begin
              phase_nxt = PH_ERR;
            end
          end else if (code == clear_code) begin
            width_nxt = start_w_r;
            next_nxt  = first_entry;
            phase_nxt = PH_FIRST;
          end else if (code == end_code) begin
            phase_nxt = PH_DONE;
          end else if ({1'b0, code} > next_r) begin
            phase_nxt = PH_ERR;
          end else begin
            // Repeat case leaves slot 0 free for the first character
            rep_nxt   = ({1'b0, code} == next_r);
            walk_nxt  = ({1'b0, code} == next_r) ? prev_r : code;
            sp_nxt    = ({1'b0, code} == next_r) ? CW'(1) : CW'(0);
            cnt_nxt   = ({1'b0, code} == next_r) ? CW'(1) : CW'(0);
            code_nxt  = code;
            state_nxt = S_WALK_RD;
          end
        end
      end

      // Walk the prefix chain; a root code ends it
      S_WALK_RD: begin
        if ({1'b0, walk_r} >= first_entry) begin
          state_nxt = S_WALK_DT;
        end else begin
          st_we     = 1'b1;
          st_wd     = walk_r[7:0];
          sp_nxt    = sp_r + CW'(1);
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_WALK_DT: begin
        st_we     = 1'b1;
        st_wd     = suffix_q;
        sp_nxt    = sp_r + CW'(1);
        cnt_nxt   = cnt_r + CW'(1);
        walk_nxt  = prefix_q;
        state_nxt = S_WALK_RD;
      end

      // Check the pixel limit, add the table entry, grow the width
      S_FIN: begin
        state_nxt = S_DEC;
        if (pix_sum > (LW+1)'(limit_r)) begin
          phase_nxt = PH_ERR;
          sp_nxt    = '0;
        end else begin
          if (rep_r) begin
            st_we = 1'b1;
            st_wa = '0;
            st_wd = walk_r[7:0];
          end
          pix_nxt = LW'(pix_sum);
          if (next_r < CW'(glpd_pkg::TABLE_DEPTH)) begin
            tb_we    = 1'b1;
            next_nxt = next_inc;
            if (next_inc == (CW'(1) << width_r) &&
                width_r < 4'(glpd_pkg::MAX_CODE_BITS)) begin
              width_nxt = width_r + 4'd1;
            end
          end
          prev_nxt = code_r;
        end
      end

      // Load the output register
      S_RESP: begin
        ov_nxt      = 1'b1;
        o_pixel_nxt = res_pixel_r;
        o_pv_nxt    = res_valid_r;
        o_last_nxt  = res_last_r || (pop_chk_r && phase_r == PH_DONE && sp_r == '0);
        o_taken_nxt = res_taken_r;
        o_pend_nxt  = (sp_r != '0);
        o_done_nxt  = (phase_r == PH_DONE);
        o_err_nxt   = (phase_r == PH_ERR);
        state_nxt   = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;    phase_r <= PH_FIRST;
      min_r <= 4'd8;        limit_r <= '0;
      sp_r <= '0;           acc_r <= '0;          bits_r <= '0;
      width_r <= 4'd9;      start_w_r <= 4'd9;    root_r <= 9'd256;
      next_r <= CW'(258);   prev_r <= '0;         bbl_r <= '0;
      pix_r <= '0;          ended_r <= 1'b0;      walk_r <= '0;
      cnt_r <= '0;          code_r <= '0;         rep_r <= 1'b0;
      pop_chk_r <= 1'b0;    res_pixel_r <= '0;    res_valid_r <= 1'b0;
      res_last_r <= 1'b0;   res_taken_r <= 1'b0;  ov_r <= 1'b0;
      o_pixel_r <= '0;      o_pv_r <= 1'b0;       o_last_r <= 1'b0;
      o_taken_r <= 1'b0;    o_pend_r <= 1'b0;     o_done_r <= 1'b0;
      o_err_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt;
      sp_r <= sp_nxt;       acc_r <= acc_nxt;     bits_r <= bits_nxt;
      width_r <= width_nxt; start_w_r <= start_w_nxt; root_r <= root_nxt;
      next_r <= next_nxt;   prev_r <= prev_nxt;   bbl_r <= bbl_nxt;
      pix_r <= pix_nxt;     ended_r <= ended_nxt; walk_r <= walk_nxt;
      cnt_r <= cnt_nxt;     code_r <= code_nxt;   rep_r <= rep_nxt;
      pop_chk_r <= pop_chk_nxt; res_pixel_r <= res_pixel_nxt;
      res_valid_r <= res_valid_nxt; res_last_r <= res_last_nxt;
      res_taken_r <= res_taken_nxt; ov_r <= ov_nxt;
      o_pixel_r <= o_pixel_nxt; o_pv_r <= o_pv_nxt; o_last_r <= o_last_nxt;
      o_taken_r <= o_taken_nxt; o_pend_r <= o_pend_nxt; o_done_r <= o_done_nxt;
      o_err_r <= o_err_nxt;
      // Register writes on the configuration transfer
      if (cfg_bus.valid) begin
        if (cfg_bus.index == glpd_pkg::CFG_MIN_CODE_SIZE) min_r <= cfg_bus.wdata[3:0];
        else                                               limit_r <= cfg_bus.wdata;
      end
    end
  end

endmodule

FILE: src/glpd_checker.sv
// Port-level checks for the GIF LZW pixel decoder, attached by bind.
// Depends on assert_macros.svh and the top level gif_lzw_pixel_decoder.
`include "assert_macros.svh"
module glpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel,
  input logic       pixel_valid,
  input logic       last_pixel,
  input logic       byte_taken,
  input logic       pixels_pending,
  input logic       frame_done,
  input logic       format_error
);
  // A stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel))
  // One item at a time: no transfer right after a transfer
  `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // A pull never consumes a byte
  `ASSERT_IMPLIES(a_pull_no_byte, out_valid, !(pixel_valid && byte_taken))
  // The last pixel leaves nothing pending
  `ASSERT_IMPLIES(a_last_empty, out_valid && last_pixel, pixel_valid && !pixels_pending)
  // Done and error exclude each other
  `ASSERT_IMPLIES(a_done_err, out_valid, !(frame_done && format_error))
endmodule

bind gif_lzw_pixel_decoder glpd_checker u_glpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .pixel          (out_bus.pixel),
  .pixel_valid    (out_bus.pixel_valid),
  .last_pixel     (out_bus.last_pixel),
  .byte_taken     (out_bus.byte_taken),
  .pixels_pending (out_bus.pixels_pending),
  .frame_done     (out_bus.frame_done),
  .format_error   (out_bus.format_error)
);
